/* rtl/rosi_pkg.sv */
// Shared types, constants and helper functions for the ray versus oriented box slab test.
// No dependencies. All other files of the block use it by scoped names.
package rosi_pkg;

	// Fixed-point format of every coordinate, distance and dot product.
	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int THR_BITS = 17;
	// Scaled product of two coordinates, and the sum of three of them.
	localparam int PROD_BITS = 48;
	localparam int ACC_BITS = 50;
	// Dividend of the slab distance: dot product plus a box bound.
	localparam int NUM_BITS = COORD_BITS + 1;

	localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic [THR_BITS-1:0] THR_RESET = 17'd66;

	typedef logic [2:0] slot_t;

	// Vector slots of the store.
	localparam slot_t SLOT_ORIGIN = 3'd0;
	localparam slot_t SLOT_DIR = 3'd1;
	localparam slot_t SLOT_BMIN = 3'd2;
	localparam slot_t SLOT_BMAX = 3'd3;
	localparam slot_t SLOT_AXIS_X = 3'd4;
	localparam slot_t SLOT_POSITION = 3'd7;

	typedef struct packed {
		logic [2:0] req_type;
		logic signed [31:0] comp_x;
		logic signed [31:0] comp_y;
		logic signed [31:0] comp_z;
		logic go;
	} in_item_t;

	typedef struct packed {
		logic hit;
		logic signed [31:0] t_near;
		logic signed [31:0] t_far;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} out_item_t;

	// Clamp a wide signed value to the coordinate range.
	function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [ACC_BITS-1:0] v);
		logic signed [COORD_BITS-1:0] r;
		if (v > ACC_BITS'(COORD_MAX)) begin
			r = COORD_MAX;
		end else if (v < ACC_BITS'(COORD_MIN)) begin
			r = COORD_MIN;
		end else begin
			r = v[COORD_BITS-1:0];
		end
		return r;
	endfunction

endpackage

/* rtl/ray_obb_slab_intersection.sv */
// Top level of the ray versus oriented box slab test: vector store, sequencer,
// result register. Depends on rosi_pkg, rosi_mul and rosi_div.
//
// Usage:
// - Input channel (in_valid, in_stall, in_data): each transfer stores one vector
//   in slot req_type. With go set, the slab test then runs on the stored vectors.
// - Output channel (out_valid, out_stall, out_data): one result per go transfer.
// - Configuration channel (cfg_valid, cfg_ready, cfg_data): writes the parallel
//   threshold; cfg_ready is always high. Write it only while the block is idle.
// Flow:
// - A transfer without go leaves in_stall low.
// - A go transfer holds in_stall high for the whole test. The shared multiplier
//   runs six products per axis and the serial divider computes two slab
//   distances per axis that is not parallel.
// Reset clears the sequencer, the output valid and sets the threshold to 66;
// stored vectors are undefined until written.
// While the receiver stalls, the result waits in the output register and the
// next test holds in its last step until the register frees.
module ray_obb_slab_intersection (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  rosi_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rosi_pkg::out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [rosi_pkg::THR_BITS-1:0] cfg_data
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_FETCH = 12'b0000_0000_0010,
		S_AXRD  = 12'b0000_0000_0100,
		S_AXCAP = 12'b0000_0000_1000,
		S_MUL   = 12'b0000_0001_0000,
		S_SAT   = 12'b0000_0010_0000,
		S_CHK   = 12'b0000_0100_0000,
		S_DIV1  = 12'b0000_1000_0000,
		S_DIV2  = 12'b0001_0000_0000,
		S_PNT   = 12'b0010_0000_0000,
		S_FIN   = 12'b0100_0000_0000,
		S_SPARE = 12'b1000_0000_0000
	} seq_state_t;

	seq_state_t state_q;
	logic [2:0] cnt_q;
	logic [1:0] axis_q;
	logic out_valid_q;
	logic [rosi_pkg::THR_BITS-1:0] thr_q;

	logic [31:0] mem_q [3][8];
	rosi_pkg::slot_t rd_addr;
	logic signed [31:0] rd_q [3];

	logic signed [31:0] delta_q [3];
	logic signed [31:0] org_q [3];
	logic signed [31:0] dir_q [3];
	logic signed [31:0] bmin_q [3];
	logic signed [31:0] bmax_q [3];
	logic signed [31:0] axv_q [3];
	logic signed [rosi_pkg::ACC_BITS-1:0] e_acc_q;
	logic signed [rosi_pkg::ACC_BITS-1:0] f_acc_q;
	logic signed [31:0] e_q;
	logic signed [31:0] f_q;
	logic signed [31:0] t1_q;
	logic signed [31:0] lo_q;
	logic signed [31:0] hi_q;
	logic signed [31:0] pt_q [3];
	logic hit_q;
	rosi_pkg::out_item_t out_q;

	logic in_xfer;
	logic fin_load;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [rosi_pkg::PROD_BITS-1:0] prod_s1;
	logic div_start;
	logic div_done;
	logic signed [rosi_pkg::NUM_BITS-1:0] div_num;
	logic signed [31:0] div_res;
	logic [31:0] f_mag;
	logic f_big;
	logic out_slab;
	logic signed [31:0] t_small;
	logic signed [31:0] t_big;
	logic signed [31:0] new_hi;
	logic signed [31:0] new_lo;
	logic slab_miss;
	logic axis_done;
	logic go_miss;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer = in_valid && (state_q == S_IDLE);
	assign fin_load = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign cfg_ready = 1'b1;

	// Store read address: the fixed slots during fetch, then one axis per pass.
	always_comb begin
		rd_addr = rosi_pkg::SLOT_ORIGIN;
		if (state_q == S_FETCH) begin
			case (cnt_q)
				3'd0: rd_addr = rosi_pkg::SLOT_POSITION;
				3'd1: rd_addr = rosi_pkg::SLOT_ORIGIN;
				3'd2: rd_addr = rosi_pkg::SLOT_DIR;
				3'd3: rd_addr = rosi_pkg::SLOT_BMIN;
				3'd4: rd_addr = rosi_pkg::SLOT_BMAX;
				default: rd_addr = rosi_pkg::SLOT_ORIGIN;
			endcase
		end else if (state_q == S_AXRD) begin
			rd_addr = rosi_pkg::SLOT_AXIS_X + {1'b0, axis_q};
		end
	end

	// Vector store: one array per component, written on every input transfer.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mem_q[0][in_data.req_type] <= in_data.comp_x;
			mem_q[1][in_data.req_type] <= in_data.comp_y;
			mem_q[2][in_data.req_type] <= in_data.comp_z;
		end
		for (int c = 0; c < 3; c++) begin
			rd_q[c] <= $signed(mem_q[c][rd_addr]);
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_MUL) begin
			case (cnt_q)
				3'd0: begin mul_a = axv_q[0]; mul_b = delta_q[0]; end
				3'd1: begin mul_a = axv_q[1]; mul_b = delta_q[1]; end
				3'd2: begin mul_a = axv_q[2]; mul_b = delta_q[2]; end
				3'd3: begin mul_a = dir_q[0]; mul_b = axv_q[0]; end
				3'd4: begin mul_a = dir_q[1]; mul_b = axv_q[1]; end
				3'd5: begin mul_a = dir_q[2]; mul_b = axv_q[2]; end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else if (state_q == S_PNT) begin
			mul_a = lo_q;
			case (cnt_q)
				3'd0: mul_b = dir_q[0];
				3'd1: mul_b = dir_q[1];
				3'd2: mul_b = dir_q[2];
				default: mul_b = '0;
			endcase
		end
	end

	rosi_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_s1(prod_s1)
	);

	// Slab decisions for the current axis.
	always_comb begin
		f_mag = f_q[31] ? 32'(-f_q) : 32'(f_q);
		f_big = f_mag > 32'(thr_q);
		out_slab = (bmin_q[axis_q] > e_q) || (bmax_q[axis_q] < e_q);
		div_num = rosi_pkg::NUM_BITS'(e_q) + rosi_pkg::NUM_BITS'(
			(state_q == S_DIV1) ? bmax_q[axis_q] : bmin_q[axis_q]);
		div_start = ((state_q == S_CHK) && f_big) || ((state_q == S_DIV1) && div_done);
		t_small = (t1_q < div_res) ? t1_q : div_res;
		t_big = (t1_q < div_res) ? div_res : t1_q;
		new_hi = (t_big < hi_q) ? t_big : hi_q;
		new_lo = (t_small > lo_q) ? t_small : lo_q;
		slab_miss = new_hi < new_lo;
		axis_done = ((state_q == S_CHK) && !f_big && !out_slab)
			|| ((state_q == S_DIV2) && div_done && !slab_miss);
		go_miss = ((state_q == S_CHK) && !f_big && out_slab)
			|| ((state_q == S_DIV2) && div_done && slab_miss);
	end

	rosi_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (f_q),
		.done  (div_done),
		.quo   (div_res)
	);

	// Sequencer, output valid and threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			axis_q <= '0;
			out_valid_q <= 1'b0;
			thr_q <= rosi_pkg::THR_RESET;
		end else begin
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_valid && in_data.go) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd5) begin
						axis_q <= '0;
						state_q <= S_AXRD;
					end
				end
				S_AXRD: state_q <= S_AXCAP;
				S_AXCAP: begin
					cnt_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd6) begin
						state_q <= S_SAT;
					end
				end
				S_SAT: state_q <= S_CHK;
				S_CHK, S_DIV2: begin
					if (f_big && state_q == S_CHK) begin
						state_q <= S_DIV1;
					end else if (go_miss) begin
						state_q <= S_FIN;
					end else if (axis_done) begin
						cnt_q <= '0;
						if (axis_q == 2'd2) begin
							state_q <= S_PNT;
						end else begin
							axis_q <= axis_q + 2'd1;
							state_q <= S_AXRD;
						end
					end
				end
				S_DIV1: begin
					if (div_done) begin
						state_q <= S_DIV2;
					end
				end
				S_PNT: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == S_FETCH) begin
			for (int c = 0; c < 3; c++) begin
				case (cnt_q)
					3'd1: delta_q[c] <= rd_q[c];
					3'd2: begin
						org_q[c] <= rd_q[c];
						delta_q[c] <= rosi_pkg::sat_coord(rosi_pkg::ACC_BITS'(delta_q[c])
							- rosi_pkg::ACC_BITS'(rd_q[c]));
					end
					3'd3: dir_q[c] <= rd_q[c];
					3'd4: bmin_q[c] <= rd_q[c];
					3'd5: bmax_q[c] <= rd_q[c];
					default: ;
				endcase
			end
			lo_q <= '0;
			hi_q <= rosi_pkg::COORD_MAX;
		end
		if (state_q == S_AXCAP) begin
			for (int c = 0; c < 3; c++) begin
				axv_q[c] <= rd_q[c];
			end
			e_acc_q <= '0;
			f_acc_q <= '0;
		end
		// Products arrive in the cycle after their operands.
		if (state_q == S_MUL && cnt_q != 3'd0) begin
			if (cnt_q <= 3'd3) begin
				e_acc_q <= e_acc_q + rosi_pkg::ACC_BITS'(prod_s1);
			end else begin
				f_acc_q <= f_acc_q + rosi_pkg::ACC_BITS'(prod_s1);
			end
		end
		if (state_q == S_SAT) begin
			e_q <= rosi_pkg::sat_coord(e_acc_q);
			f_q <= rosi_pkg::sat_coord(f_acc_q);
		end
		if (state_q == S_DIV1 && div_done) begin
			t1_q <= div_res;
		end
		if (state_q == S_DIV2 && div_done) begin
			lo_q <= new_lo;
			hi_q <= new_hi;
		end
		if (go_miss) begin
			hit_q <= 1'b0;
		end else if (axis_done && axis_q == 2'd2) begin
			hit_q <= 1'b1;
		end
		// Hit point: origin plus the scaled product, one component a cycle.
		if (state_q == S_PNT) begin
			case (cnt_q)
				3'd1: pt_q[0] <= rosi_pkg::sat_coord(rosi_pkg::ACC_BITS'(org_q[0])
					+ rosi_pkg::ACC_BITS'(prod_s1));
				3'd2: pt_q[1] <= rosi_pkg::sat_coord(rosi_pkg::ACC_BITS'(org_q[1])
					+ rosi_pkg::ACC_BITS'(prod_s1));
				3'd3: pt_q[2] <= rosi_pkg::sat_coord(rosi_pkg::ACC_BITS'(org_q[2])
					+ rosi_pkg::ACC_BITS'(prod_s1));
				default: ;
			endcase
		end
		if (fin_load) begin
			if (hit_q) begin
				out_q <= '{hit: 1'b1, t_near: lo_q, t_far: hi_q,
					point_x: pt_q[0], point_y: pt_q[1], point_z: pt_q[2]};
			end else begin
				out_q <= '0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_data.go) |=> in_stall)
		else $error("Test transfer did not start the sequencer.");

	a_store_only: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !in_data.go) |=> !in_stall)
		else $error("Store-only transfer left the block busy.");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.hit) |-> (out_data.t_near == 0 && out_data.t_far == 0
		&& out_data.point_x == 0 && out_data.point_y == 0 && out_data.point_z == 0))
		else $error("Miss result carries nonzero fields.");

	a_hit_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.hit) |-> (!out_data.t_near[31]
		&& out_data.t_near <= out_data.t_far))
		else $error("Hit result has an invalid distance interval.");
`endif

endmodule

/* rtl/rosi_mul.sv */
// Shared fixed-point multiplier: magnitude product scaled down by the fraction bits,
// truncated toward zero, sign restored, result registered. Depends on rosi_pkg.
module rosi_mul (
	input  logic clk,
	input  logic signed [rosi_pkg::COORD_BITS-1:0] a,
	input  logic signed [rosi_pkg::COORD_BITS-1:0] b,
	output logic signed [rosi_pkg::PROD_BITS-1:0] p_s1
);

	logic [rosi_pkg::COORD_BITS-1:0] mag_a;
	logic [rosi_pkg::COORD_BITS-1:0] mag_b;
	logic [2*rosi_pkg::COORD_BITS-1:0] prod;
	logic [rosi_pkg::PROD_BITS-1:0] scaled;

	// Work on magnitudes so that the scaling truncates toward zero.
	always_comb begin
		mag_a = a[rosi_pkg::COORD_BITS-1] ? rosi_pkg::COORD_BITS'(-a) : rosi_pkg::COORD_BITS'(a);
		mag_b = b[rosi_pkg::COORD_BITS-1] ? rosi_pkg::COORD_BITS'(-b) : rosi_pkg::COORD_BITS'(b);
		prod = mag_a * mag_b;
		scaled = prod[rosi_pkg::FRAC_BITS +: rosi_pkg::PROD_BITS];
	end

	// Register the signed product.
	always_ff @(posedge clk) begin
		if (a[rosi_pkg::COORD_BITS-1] ^ b[rosi_pkg::COORD_BITS-1]) begin
			p_s1 <= -$signed(scaled);
		end else begin
			p_s1 <= $signed(scaled);
		end
	end

endmodule

/* rtl/rosi_div.sv */
// Serial fixed-point divider: one quotient bit per cycle, truncated toward zero,
// saturating to the coordinate range. Depends on rosi_pkg.
module rosi_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [rosi_pkg::NUM_BITS-1:0] num,
	input  logic signed [rosi_pkg::COORD_BITS-1:0] den,
	output logic done,
	output logic signed [rosi_pkg::COORD_BITS-1:0] quo
);

	localparam int QB = rosi_pkg::COORD_BITS - 1;
	localparam int CHK_BITS = rosi_pkg::NUM_BITS + rosi_pkg::FRAC_BITS;

	typedef enum logic [3:0] {
		DV_IDLE = 4'b0001,
		DV_CHK  = 4'b0010,
		DV_RUN  = 4'b0100,
		DV_DONE = 4'b1000
	} div_state_t;

	div_state_t state_q;
	logic [4:0] cnt_q;
	logic [rosi_pkg::NUM_BITS-1:0] n_q;
	logic [rosi_pkg::COORD_BITS-1:0] d_q;
	logic neg_q;
	logic sat_q;
	logic [rosi_pkg::NUM_BITS-1:0] r_q;
	logic [QB-1:0] sh_q;
	logic [QB-1:0] q_q;
	logic ovf;
	logic [rosi_pkg::NUM_BITS-1:0] r_shift;
	logic take;

	// The quotient does not fit when n >= d * 2^(COORD_BITS-1-FRAC_BITS).
	always_comb begin
		ovf = CHK_BITS'(n_q) >=
			(CHK_BITS'(d_q) << (rosi_pkg::COORD_BITS - 1 - rosi_pkg::FRAC_BITS));
		r_shift = {r_q[rosi_pkg::NUM_BITS-2:0], sh_q[QB-1]};
		take = r_shift >= rosi_pkg::NUM_BITS'(d_q);
	end

	// Sequencer: overflow check, then, unless it overflows, one restoring step per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				DV_IDLE, DV_DONE: begin
					state_q <= start ? DV_CHK : DV_IDLE;
				end
				DV_CHK: begin
					cnt_q <= '0;
					state_q <= ovf ? DV_DONE : DV_RUN;
				end
				DV_RUN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(QB - 1)) begin
						state_q <= DV_DONE;
					end
				end
				default: state_q <= DV_IDLE;
			endcase
		end
	end

	// Operand and remainder registers.
	always_ff @(posedge clk) begin
		if (start && (state_q == DV_IDLE || state_q == DV_DONE)) begin
			n_q <= num[rosi_pkg::NUM_BITS-1] ? rosi_pkg::NUM_BITS'(-num) : rosi_pkg::NUM_BITS'(num);
			d_q <= den[rosi_pkg::COORD_BITS-1] ? rosi_pkg::COORD_BITS'(-den)
				: rosi_pkg::COORD_BITS'(den);
			neg_q <= num[rosi_pkg::NUM_BITS-1] ^ den[rosi_pkg::COORD_BITS-1];
		end
		if (state_q == DV_CHK) begin
			sat_q <= ovf;
			r_q <= n_q >> (QB - rosi_pkg::FRAC_BITS);
			sh_q <= {n_q[QB-rosi_pkg::FRAC_BITS-1:0], {rosi_pkg::FRAC_BITS{1'b0}}};
			q_q <= '0;
		end
		if (state_q == DV_RUN) begin
			r_q <= take ? r_shift - rosi_pkg::NUM_BITS'(d_q) : r_shift;
			sh_q <= {sh_q[QB-2:0], 1'b0};
			q_q <= {q_q[QB-2:0], take};
		end
	end

	// Result with sign and saturation applied.
	always_comb begin
		done = (state_q == DV_DONE);
		if (sat_q) begin
			quo = neg_q ? rosi_pkg::COORD_MIN : rosi_pkg::COORD_MAX;
		end else if (neg_q) begin
			quo = -$signed({1'b0, q_q});
		end else begin
			quo = $signed({1'b0, q_q});
		end
	end

endmodule
